// ----- design/uniform_grid_particle_index_assert.svh -----
// Assertion macros for the uniform grid particle index.
// Included by design files that carry concurrent assertions.
`ifndef UNIFORM_GRID_PARTICLE_INDEX_ASSERT_SVH
`define UNIFORM_GRID_PARTICLE_INDEX_ASSERT_SVH
`define UGPI_ASSERT_IMPL(label, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define UGPI_ASSERT_NEXT(label, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

// ----- design/ugpi_pkg.sv -----
// Package for the uniform grid particle index: types, sizes and codes.
// No dependencies.
package ugpi_pkg;
    localparam int GridDim      = 32;
    localparam int MaxParticles = 1024;
    localparam int AxisBits     = $clog2(GridDim);
    localparam int CellBits     = 3 * AxisBits;
    localparam int PidBits      = $clog2(MaxParticles);
    localparam int NumCells     = GridDim * GridDim * GridDim;

    localparam logic [2:0] REG_ORIGIN_X = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [2:0] REG_CELL_SIZE = 3'd3;
    localparam logic [2:0] REG_CELLS_PER_AXIS = 3'd4;

    localparam logic [1:0] OP_CLEAR   = 2'd0;
    localparam logic [1:0] OP_MOVE    = 2'd1;
    localparam logic [1:0] OP_QUERY   = 2'd2;
    localparam logic [1:0] OP_IGNORED = 2'd3;

    typedef struct packed {
        logic [1:0]         operation;
        logic [9:0]         particle_id;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } cmd_t;

    typedef struct packed {
        logic       status;
        logic       found;
        logic [9:0] neighbor_id;
        logic [4:0] cell_x;
        logic [4:0] cell_y;
        logic [4:0] cell_z;
        logic       last;
    } result_t;
endpackage

// ----- design/uniform_grid_particle_index.sv -----
// Uniform grid particle index: top level with both state memories.
// Depends on ugpi_pkg and uniform_grid_particle_index_assert.svh.
//
// Start a command with start while busy is low; results come with
// result_valid, one cycle each, and the receiver cannot stall them. Each
// command first divides the three axis distances by cell_size with one
// shared restoring divider, one load and 33 steps per axis. A move then
// reads the old entry, frees it, writes and finishes in a done state. A
// query walks each of the 27 offset slots through an address, a wait and
// a check state, the center slot included and skipped, and then a done
// state, with busy high. An unused code reports right after the
// division, and so does a clear, which then sweeps the 32768-entry cell
// memory and the 1024-entry particle memory, one entry a cycle with busy
// high; the same sweep runs after reset. Configuration writes are taken
// at any time.
`include "uniform_grid_particle_index_assert.svh"
module uniform_grid_particle_index
    import ugpi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  cmd_t        cmd,
    output logic        busy,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic        result_valid,
    output result_t     result
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DIV, S_MV_RD, S_MV_CHK, S_MV_WR,
        S_Q_ADDR, S_Q_WAIT, S_Q_CHK, S_DONE
    } state_t;

    state_t state_reg;
    logic signed [31:0] org_x_reg, org_y_reg, org_z_reg;
    logic [30:0] csize_reg;
    logic [5:0]  cpa_reg;
    cmd_t        cmd_reg;

    // Cell memory: valid bit plus particle id. Particle memory: valid plus cell.
    logic [PidBits:0]  cell_mem [NumCells];
    logic [CellBits:0] part_mem [MaxParticles];
    logic [PidBits:0]  cell_rd_reg;
    logic [CellBits:0] part_rd_reg;
    logic [CellBits-1:0] cell_addr, cell_waddr;
    logic              cell_we;
    logic [PidBits:0]  cell_wdata;
    logic              part_we;
    logic [CellBits:0] part_wdata;
    logic [PidBits-1:0] part_waddr;

    logic [CellBits:0] sweep_reg;
    logic [1:0]  axis_reg;
    logic [5:0]  bit_reg;
    logic [32:0] rem_reg;
    logic [32:0] quo_reg;
    logic [32:0] dvd_reg;
    logic [32:0] ix_reg, iy_reg, iz_reg;
    logic [1:0]  dx_reg, dy_reg, dz_reg;
    logic        any_reg;
    result_t     held_reg;
    result_t     held_final;
    logic [AxisBits-1:0] nx_reg, ny_reg, nz_reg;
    logic        nvalid_reg;

    logic [5:0]  lim;
    logic [30:0] cs_eff;
    logic signed [33:0] diff;
    logic [32:0] mag;
    logic [33:0] trial;
    logic [33:0] nx_w, ny_w, nz_w;
    logic        in_grid;

    assign lim    = (cpa_reg > 6'(GridDim)) ? 6'(GridDim) : cpa_reg;
    assign cs_eff = (csize_reg == '0) ? 31'd1 : csize_reg;

    always_comb
    begin
        case (axis_reg)
            2'd0: diff = 34'(cmd_reg.pos_x) - 34'(org_x_reg);
            2'd1: diff = 34'(cmd_reg.pos_y) - 34'(org_y_reg);
            default: diff = 34'(cmd_reg.pos_z) - 34'(org_z_reg);
        endcase
        mag = diff[33] ? 33'(-diff) : diff[32:0];
    end

    assign trial   = {rem_reg, dvd_reg[32]} - {3'b0, cs_eff};
    assign in_grid = (ix_reg < 33'(lim)) && (iy_reg < 33'(lim)) && (iz_reg < 33'(lim));

    // Each offset counter runs 0..2 and stands for -1..+1; z steps fastest.
    always_comb
    begin
        nx_w = 34'(ix_reg) + 34'(dx_reg) - 34'd1;
        ny_w = 34'(iy_reg) + 34'(dy_reg) - 34'd1;
        nz_w = 34'(iz_reg) + 34'(dz_reg) - 34'd1;
    end

    always_comb
    begin
        held_final      = held_reg;
        held_final.last = 1'b1;
    end

    always_comb
    begin
        cell_we    = 1'b0;
        cell_waddr = sweep_reg[CellBits-1:0];
        cell_wdata = '0;
        part_we    = 1'b0;
        part_waddr = sweep_reg[PidBits-1:0];
        part_wdata = '0;
        cell_addr  = {nx_w[AxisBits-1:0], ny_w[AxisBits-1:0], nz_w[AxisBits-1:0]};
        case (state_reg)
            S_CLEAR:
            begin
                cell_we = 1'b1;
                part_we = (sweep_reg < (CellBits+1)'(MaxParticles));
            end
            S_MV_RD:
                cell_addr = part_rd_reg[CellBits-1:0];
            S_MV_CHK:
            begin
                cell_addr = part_rd_reg[CellBits-1:0];
                if (part_rd_reg[CellBits] && cell_rd_reg[PidBits]
                    && cell_rd_reg[PidBits-1:0] == cmd_reg.particle_id)
                begin
                    cell_we    = 1'b1;
                    cell_waddr = part_rd_reg[CellBits-1:0];
                end
            end
            S_MV_WR:
            begin
                cell_waddr = {ix_reg[AxisBits-1:0], iy_reg[AxisBits-1:0],
                              iz_reg[AxisBits-1:0]};
                cell_we    = in_grid;
                cell_wdata = {1'b1, cmd_reg.particle_id};
                part_we    = 1'b1;
                part_waddr = cmd_reg.particle_id;
                part_wdata = {in_grid, cell_waddr};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cell_we)
            cell_mem[cell_waddr] <= cell_wdata;
        cell_rd_reg <= cell_mem[cell_addr];
        if (part_we)
            part_mem[part_waddr] <= part_wdata;
        part_rd_reg <= part_mem[cmd_reg.particle_id];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            org_x_reg    <= '0;
            org_y_reg    <= '0;
            org_z_reg    <= '0;
            csize_reg    <= 31'd65536;
            cpa_reg      <= 6'd32;
            cmd_reg      <= '0;
            sweep_reg    <= '0;
            result_valid <= 1'b0;
            result       <= '0;
            axis_reg     <= '0;
            bit_reg      <= '0;
            rem_reg      <= '0;
            quo_reg      <= '0;
            dvd_reg      <= '0;
            ix_reg       <= '0;
            iy_reg       <= '0;
            iz_reg       <= '0;
            dx_reg       <= '0;
            dy_reg       <= '0;
            dz_reg       <= '0;
            any_reg      <= 1'b0;
            held_reg     <= '0;
            nx_reg       <= '0;
            ny_reg       <= '0;
            nz_reg       <= '0;
            nvalid_reg   <= 1'b0;
        end
        else
        begin
            result_valid <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ORIGIN_X:       org_x_reg <= cfg_data;
                    REG_ORIGIN_Y:       org_y_reg <= cfg_data;
                    REG_ORIGIN_Z:       org_z_reg <= cfg_data;
                    REG_CELL_SIZE:      csize_reg <= cfg_data[30:0];
                    REG_CELLS_PER_AXIS: cpa_reg   <= cfg_data[5:0];
                    default: ;
                endcase
            end
            case (state_reg)
                S_CLEAR:
                begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_reg == (CellBits+1)'(NumCells - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg  <= cmd;
                        axis_reg <= '0;
                        bit_reg  <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (bit_reg == '0)
                    begin
                        dvd_reg <= mag;
                        rem_reg <= '0;
                        quo_reg <= '0;
                        bit_reg <= 6'd1;
                    end
                    else
                    begin
                        dvd_reg <= {dvd_reg[31:0], 1'b0};
                        if (!trial[33])
                        begin
                            rem_reg <= trial[32:0];
                            quo_reg <= {quo_reg[31:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= {rem_reg[31:0], dvd_reg[32]};
                            quo_reg <= {quo_reg[31:0], 1'b0};
                        end
                        if (bit_reg == 6'd33)
                        begin
                            bit_reg <= '0;
                            axis_reg <= axis_reg + 1'b1;
                            case (axis_reg)
                                2'd0: ix_reg <= {quo_reg[31:0], !trial[33]};
                                2'd1: iy_reg <= {quo_reg[31:0], !trial[33]};
                                default: iz_reg <= {quo_reg[31:0], !trial[33]};
                            endcase
                            if (axis_reg == 2'd2)
                            begin
                                dx_reg  <= '0;
                                dy_reg  <= '0;
                                dz_reg  <= '0;
                                any_reg <= 1'b0;
                                case (cmd_reg.operation)
                                    OP_CLEAR:
                                    begin
                                        sweep_reg <= '0;
                                        state_reg <= S_CLEAR;
                                        result_valid <= 1'b1;
                                        result <= '{default: '0, last: 1'b1};
                                    end
                                    OP_MOVE:  state_reg <= S_MV_RD;
                                    OP_QUERY: state_reg <= S_Q_ADDR;
                                    default:
                                    begin
                                        state_reg <= S_DONE;
                                        result_valid <= 1'b1;
                                        result <= '{default: '0, last: 1'b1};
                                    end
                                endcase
                            end
                        end
                        else
                            bit_reg <= bit_reg + 1'b1;
                    end
                end
                S_MV_RD:  state_reg <= S_MV_CHK;
                S_MV_CHK: state_reg <= S_MV_WR;
                S_MV_WR:
                begin
                    state_reg    <= S_DONE;
                    result_valid <= 1'b1;
                    result <= '{default: '0, status: !in_grid, last: 1'b1};
                end
                S_Q_ADDR:
                begin
                    nx_reg <= nx_w[AxisBits-1:0];
                    ny_reg <= ny_w[AxisBits-1:0];
                    nz_reg <= nz_w[AxisBits-1:0];
                    nvalid_reg <= !(dx_reg == 2'd1 && dy_reg == 2'd1 && dz_reg == 2'd1)
                                  && nx_w < 34'(lim) && ny_w < 34'(lim)
                                  && nz_w < 34'(lim);
                    state_reg <= S_Q_WAIT;
                end
                S_Q_WAIT: state_reg <= S_Q_CHK;
                S_Q_CHK:
                begin
                    // Hold a hit one step so the final one can carry last.
                    if (nvalid_reg && cell_rd_reg[PidBits])
                    begin
                        if (any_reg)
                        begin
                            result_valid <= 1'b1;
                            result       <= held_reg;
                        end
                        any_reg  <= 1'b1;
                        held_reg <= '{status: 1'b0, found: 1'b1,
                                      neighbor_id: cell_rd_reg[PidBits-1:0],
                                      cell_x: 5'(nx_reg), cell_y: 5'(ny_reg),
                                      cell_z: 5'(nz_reg), last: 1'b0};
                    end
                    if (dx_reg == 2'd2 && dy_reg == 2'd2 && dz_reg == 2'd2)
                        state_reg <= S_DONE;
                    else
                    begin
                        if (dz_reg == 2'd2)
                        begin
                            dz_reg <= '0;
                            if (dy_reg == 2'd2)
                            begin
                                dy_reg <= '0;
                                dx_reg <= dx_reg + 1'b1;
                            end
                            else
                                dy_reg <= dy_reg + 1'b1;
                        end
                        else
                            dz_reg <= dz_reg + 1'b1;
                        state_reg <= S_Q_ADDR;
                    end
                end
                S_DONE:
                begin
                    if (cmd_reg.operation == OP_QUERY)
                    begin
                        result_valid <= 1'b1;
                        if (any_reg)
                            result <= held_final;
                        else
                            result <= '{default: '0, last: 1'b1};
                    end
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy = (state_reg != S_IDLE);

    `UGPI_ASSERT_IMPL(a_no_start_busy, result_valid && state_reg == S_IDLE,
        result.last, "result in idle without last")
    `UGPI_ASSERT_NEXT(a_move_last, state_reg == S_MV_WR, result_valid && result.last,
        "move did not report a final result")
    `UGPI_ASSERT_NEXT(a_done_idle, state_reg == S_DONE, state_reg == S_IDLE,
        "done did not return to idle")
    `UGPI_ASSERT_IMPL(a_found_status, result_valid && result.found,
        !result.status, "found item with status set")
endmodule

// ----- dv/tb_uniform_grid_particle_index.sv -----
// Self-checking testbench for the uniform grid particle index.
// Depends on ugpi_pkg and the uniform_grid_particle_index top level.
`timescale 1ns / 1ps
module tb_uniform_grid_particle_index;
    import ugpi_pkg::*;

    localparam int WatchdogLimit = 200000;
    localparam int DrainCycles   = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    cmd_t        cmd = '0;
    logic        busy;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        result_valid;
    result_t     result;

    uniform_grid_particle_index dut (
        .clk(clk), .rst_n(rst_n), .start(start), .cmd(cmd), .busy(busy),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .result_valid(result_valid), .result(result)
    );

    always #5 clk = ~clk;

    // Shadow copy of the grid state and registers.
    longint      org_x, org_y, org_z;
    bit [30:0]   cell_size;
    bit [5:0]    cells_per_axis;
    bit          cell_used [NumCells];
    bit [9:0]    cell_pid  [NumCells];
    bit          part_placed [MaxParticles];
    int          part_cell   [MaxParticles];

    cmd_t        pending_cmds[$];
    result_t     expected_results[$];
    int          error_count = 0;
    int          idle_pct = 36;
    int          quiet_cycles = 0;

    function automatic void add_expected(result_t r);
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic longint axis_cell(logic [31:0] raw, longint org);
        longint d;
        longint cs;
        d = longint'($signed(raw)) - org;
        if (d < 0)
            d = -d;
        cs = (cell_size == 0) ? 1 : longint'(cell_size);
        return d / cs;
    endfunction

    function automatic void predict_results(cmd_t c);
        longint  ix, iy, iz, lim, nx, ny, nz;
        int      flat, n;
        bit      in_grid;
        result_t r;
        ix = axis_cell(c.pos_x, org_x);
        iy = axis_cell(c.pos_y, org_y);
        iz = axis_cell(c.pos_z, org_z);
        lim = (cells_per_axis > GridDim) ? GridDim : cells_per_axis;
        r = '0;
        r.last = 1'b1;
        if (c.operation == OP_CLEAR)
        begin
            for (int i = 0; i < NumCells; i++)
                cell_used[i] = 1'b0;
            for (int i = 0; i < MaxParticles; i++)
                part_placed[i] = 1'b0;
            add_expected(r);
        end
        else if (c.operation == OP_MOVE)
        begin
            in_grid = ix < lim && iy < lim && iz < lim;
            if (part_placed[c.particle_id])
            begin
                flat = part_cell[c.particle_id];
                if (cell_used[flat] && cell_pid[flat] == c.particle_id)
                    cell_used[flat] = 1'b0;
                part_placed[c.particle_id] = 1'b0;
            end
            if (in_grid)
            begin
                flat = int'((ix * GridDim + iy) * GridDim + iz);
                cell_used[flat] = 1'b1;
                cell_pid[flat] = c.particle_id;
                part_cell[c.particle_id] = flat;
                part_placed[c.particle_id] = 1'b1;
            end
            r.status = !in_grid;
            add_expected(r);
        end
        else if (c.operation == OP_QUERY)
        begin
            n = 0;
            for (int dx = -1; dx <= 1; dx++)
                for (int dy = -1; dy <= 1; dy++)
                    for (int dz = -1; dz <= 1; dz++)
                    begin
                        nx = ix + dx;
                        ny = iy + dy;
                        nz = iz + dz;
                        if (dx == 0 && dy == 0 && dz == 0)
                            continue;
                        if (nx < 0 || ny < 0 || nz < 0
                            || nx >= lim || ny >= lim || nz >= lim)
                            continue;
                        flat = int'((nx * GridDim + ny) * GridDim + nz);
                        if (!cell_used[flat])
                            continue;
                        r = '0;
                        r.found = 1'b1;
                        r.neighbor_id = cell_pid[flat];
                        r.cell_x = nx[4:0];
                        r.cell_y = ny[4:0];
                        r.cell_z = nz[4:0];
                        add_expected(r);
                        n++;
                    end
            if (n == 0)
            begin
                r = '0;
                r.last = 1'b1;
                add_expected(r);
            end
            else
            begin
                expected_results[$].last = 1'b1;
            end
        end
        else
        begin
            add_expected(r);
        end
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, field, got, want);
        error_count++;
    endtask

    // Driver: a new command goes out once the previous one has transferred.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                predict_results(cmd);
            if (!start || !busy)
            begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    start <= 1'b1;
                    cmd <= pending_cmds.pop_front();
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor and watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result count", 1, 0);
                end
                else
                begin
                    result_t e;
                    e = expected_results.pop_front();
                    if (result.status !== e.status)
                        report_mismatch("status", result.status, e.status);
                    if (result.found !== e.found)
                        report_mismatch("found", result.found, e.found);
                    if (result.neighbor_id !== e.neighbor_id)
                        report_mismatch("neighbor_id", result.neighbor_id, e.neighbor_id);
                    if (result.cell_x !== e.cell_x)
                        report_mismatch("cell_x", result.cell_x, e.cell_x);
                    if (result.cell_y !== e.cell_y)
                        report_mismatch("cell_y", result.cell_y, e.cell_y);
                    if (result.cell_z !== e.cell_z)
                        report_mismatch("cell_z", result.cell_z, e.cell_z);
                    if (result.last !== e.last)
                        report_mismatch("last", result.last, e.last);
                end
            end
            if (result_valid || (start && !busy))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WatchdogLimit)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            REG_ORIGIN_X:       org_x = longint'($signed(value));
            REG_ORIGIN_Y:       org_y = longint'($signed(value));
            REG_ORIGIN_Z:       org_z = longint'($signed(value));
            REG_CELL_SIZE:      cell_size = value[30:0];
            REG_CELLS_PER_AXIS: cells_per_axis = value[5:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_grid(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                            logic [31:0] cs, logic [31:0] cpa);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_ORIGIN_Z, oz);
        write_reg(REG_CELL_SIZE, cs);
        write_reg(REG_CELLS_PER_AXIS, cpa);
    endtask

    task automatic queue_cmd(logic [1:0] op, logic [9:0] pid,
                             logic [31:0] x, logic [31:0] y, logic [31:0] z);
        cmd_t c;
        c.operation = op;
        c.particle_id = pid;
        c.pos_x = x;
        c.pos_y = y;
        c.pos_z = z;
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    // Position that lands in the given cell, on either side of the origin.
    function automatic logic [31:0] pos_in_cell(longint org, longint idx);
        longint cs, off;
        cs = (cell_size == 0) ? 1 : longint'(cell_size);
        off = idx * cs + ($urandom % cs);
        if ($urandom_range(1))
            off = -off;
        return 32'(org + off);
    endfunction

    task automatic wait_drained();
        while (pending_cmds.size() > 0 || start || expected_results.size() > 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    // Mostly moves and queries clustered around one cell, with some raw noise.
    task automatic random_burst(int count, int clears_allowed);
        longint cx, cy, cz, lim;
        int     sel;
        lim = (cells_per_axis > GridDim) ? GridDim : cells_per_axis;
        if (lim == 0)
            lim = 2;
        for (int i = 0; i < count; i++)
        begin
            cx = $urandom_range(int'(lim) - 1);
            cy = $urandom_range(int'(lim) - 1);
            cz = $urandom_range(int'(lim) - 1);
            sel = $urandom_range(99);
            if (sel < 10)
            begin
                queue_cmd(2'($urandom), 10'($urandom), $urandom, $urandom, $urandom);
            end
            else if (sel < 12 && clears_allowed > 0)
            begin
                queue_cmd(OP_CLEAR, 10'($urandom), $urandom, $urandom, $urandom);
                clears_allowed--;
            end
            else if (sel < 14)
            begin
                queue_cmd(OP_IGNORED, 10'($urandom), $urandom, $urandom, $urandom);
            end
            else
            begin
                queue_cmd(sel < 60 ? OP_MOVE : OP_QUERY, 10'($urandom_range(15)),
                          pos_in_cell(org_x, cx + $urandom_range(2)),
                          pos_in_cell(org_y, cy + $urandom_range(2)),
                          pos_in_cell(org_z, cz + $urandom_range(2)));
            end
        end
        wait_drained();
    endtask

    initial
    begin
        org_x = 0;
        org_y = 0;
        org_z = 0;
        cell_size = 31'd65536;
        cells_per_axis = 6'd32;
        for (int i = 0; i < NumCells; i++)
        begin
            cell_used[i] = 1'b0;
            cell_pid[i] = '0;
        end
        for (int i = 0; i < MaxParticles; i++)
        begin
            part_placed[i] = 1'b0;
            part_cell[i] = 0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part with the reset configuration.
        queue_cmd(OP_IGNORED, 10'h3FF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_cmd(OP_MOVE, 10'd0, 32'd0, 32'd0, 32'd0);
        queue_cmd(OP_MOVE, 10'h3FF, 32'h001F_FFFF, 32'h001F_FFFF, 32'h001F_FFFF);
        queue_cmd(OP_MOVE, 10'd5, 32'h0001_0000, 32'd0, 32'd0);
        queue_cmd(OP_QUERY, 10'd0, 32'd0, 32'd0, 32'd0);
        queue_cmd(OP_QUERY, 10'd0, 32'h001E_0000, 32'h001E_8000, 32'h001E_0000);
        queue_cmd(OP_QUERY, 10'd0, 32'h000A_0000, 32'h000A_0000, 32'h000A_0000);
        queue_cmd(OP_MOVE, 10'd0, 32'h7FFF_FFFF, 32'd0, 32'd0);
        queue_cmd(OP_MOVE, 10'd7, 32'hFFFF_8000, 32'hFFFF_0001, 32'h0002_0000);
        queue_cmd(OP_MOVE, 10'd8, 32'h0000_4000, 32'h0000_0001, 32'h0002_FFFF);
        queue_cmd(OP_MOVE, 10'd7, 32'h0003_0000, 32'h0003_0000, 32'h0003_0000);
        queue_cmd(OP_QUERY, 10'd0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        queue_cmd(OP_MOVE, 10'd9, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        queue_cmd(OP_QUERY, 10'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
        queue_cmd(OP_QUERY, 10'd0, 32'h0020_0000, 32'h001F_0000, 32'h001F_0000);
        queue_cmd(OP_CLEAR, 10'h155, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678);
        queue_cmd(OP_QUERY, 10'd0, 32'h0002_0000, 32'h0002_0000, 32'h0002_0000);
        wait_drained();

        // Extreme origins, the smallest cell size and a single-cell grid.
        set_grid(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd1, 32'd1);
        random_burst(12, 0);

        // Zero cell size and an empty grid.
        set_grid(32'hFFFF_FFF0, 32'd16, 32'h8000_0000, 32'd0, 32'd0);
        random_burst(10, 0);

        // Largest cell size and axis length saturated above the grid.
        set_grid(32'd0, 32'hC000_0000, 32'h4000_0000, 32'h7FFF_FFFF, 32'd63);
        random_burst(12, 0);

        // Small grid with dense neighbors, no idling on the sender side.
        idle_pct = 0;
        set_grid(32'h0010_0000, 32'hFFF0_0000, 32'd0, 32'h0000_8000, 32'd4);
        random_burst(30, 1);
        idle_pct = 36;

        // Full grid with a random origin and cell size.
        set_grid($urandom, $urandom, $urandom, 32'($urandom_range(200000, 1)), 32'd32);
        random_burst(30, 1);

        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+design
design/ugpi_pkg.sv
design/uniform_grid_particle_index.sv
dv/tb_uniform_grid_particle_index.sv
